### src/frdpq_pkg.sv
// Shared types and codes for the floor request dual priority queue.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package frdpq_pkg;

    // Field widths on the stream ports
    localparam int FLOOR_W  = 8;
    localparam int COUNT_W  = 5;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = CMD_W + 1;
    localparam int M_TDATA_W = 40;   // 36 bits of fields padded to whole bytes
    localparam int M_TUSER_W = STATUS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 2'd0,
        CMD_REM_UP   = 2'd1,
        CMD_REM_DOWN = 2'd2,
        CMD_NOP      = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam logic DIR_DOWN = 1'b0;
    localparam logic DIR_UP   = 1'b1;

endpackage

`default_nettype wire

### src/floor_request_dual_priority_queue.sv
// Floor request dual priority queue: two sorted register arrays with
// parallel compare/shift insert and remove. Depends on frdpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel    | Dir | Handshake           | Payload
// -----------+-----+---------------------+------------------------------------------
// s_ (cmd)   | in  | s_tvalid / s_tready | tdata: floor; tuser: command, direction
// m_ (result)| out | m_tvalid / m_tready | tdata: fronts, next floor, counts, flags;
//            |     |                     | tuser: status
//
// One transaction per cycle while not stalled by m_tready: a command updates one queue
// in the cycle it is accepted (one compare per entry, one shift per entry) and
// its result is registered, so it appears in the cycle after acceptance.
// The output register frees when taken, so s_tready = !m_tvalid | m_tready.
// Reset (aresetn low, synchronous) empties both queues and the output register.
// Entry contents are not reset; only the counts say what is valid.
module floor_request_dual_priority_queue
    import frdpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int FLOOR_BITS  = 8
) (
    input  wire                   aclk,
    input  wire                   aresetn,

    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire  [S_TDATA_W-1:0]  s_tdata,   // [7:0] floor
    input  wire  [S_TUSER_W-1:0]  s_tuser,   // [1:0] command, [2] direction

    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] up_front, [15:8] down_front,
                                             // [23:16] next_floor, [28:24] up_count,
                                             // [33:29] down_count, [34] up_empty,
                                             // [35] any_pending, [39:36] zero
    output logic [M_TUSER_W-1:0]  m_tuser    // [1:0] status
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int FB = FLOOR_BITS;

    // ---------------- state ----------------
    logic [FB-1:0] up_reg   [QUEUE_DEPTH];   // ascending, smallest at entry 0
    logic [FB-1:0] up_next  [QUEUE_DEPTH];
    logic [FB-1:0] dn_reg   [QUEUE_DEPTH];   // descending, largest at entry 0
    logic [FB-1:0] dn_next  [QUEUE_DEPTH];
    logic [CW-1:0] up_used_reg, up_used_next;
    logic [CW-1:0] dn_used_reg, dn_used_next;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    // ---------------- decode ----------------
    cmd_t          cmd;
    logic          dir;
    logic [FB-1:0] floor_in;
    logic [FB+7:0] floor_ext;
    logic          s_acc;

    assign cmd       = cmd_t'(s_tuser[CMD_W-1:0]);
    assign dir       = s_tuser[CMD_W];
    assign floor_ext = {{FB{1'b0}}, s_tdata[7:0]};
    assign floor_in  = floor_ext[FB-1:0];
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_acc     = s_tvalid && s_tready;

    logic up_full, dn_full, up_emp, dn_emp;
    assign up_full = (up_used_reg == CW'(QUEUE_DEPTH));
    assign dn_full = (dn_used_reg == CW'(QUEUE_DEPTH));
    assign up_emp  = (up_used_reg == '0);
    assign dn_emp  = (dn_used_reg == '0);

    logic do_up_ins, do_dn_ins, do_up_rem, do_dn_rem;
    status_t status;

    always_comb begin
        do_up_ins = 1'b0;
        do_dn_ins = 1'b0;
        do_up_rem = 1'b0;
        do_dn_rem = 1'b0;
        status    = ST_DONE;
        case (cmd)
            CMD_ADD: begin
                if (dir == DIR_UP) begin
                    if (up_full) status = ST_FULL;
                    else do_up_ins = 1'b1;
                end else begin
                    if (dn_full) status = ST_FULL;
                    else do_dn_ins = 1'b1;
                end
            end
            CMD_REM_UP: begin
                if (up_emp) status = ST_EMPTY;
                else do_up_rem = 1'b1;
            end
            CMD_REM_DOWN: begin
                if (dn_emp) status = ST_EMPTY;
                else do_dn_rem = 1'b1;
            end
            default: status = ST_DONE;
        endcase
    end

    // ---------------- insert / remove datapath ----------------
    // An entry "yields" when it is unused or would sort behind the new floor.
    // Yield flags are monotone, so the first yielding entry takes the new floor
    // and later ones take their predecessor. Equal floors stay ahead.
    logic [QUEUE_DEPTH-1:0] up_yield, dn_yield;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            up_yield[i] = (CW'(i) >= up_used_reg) || (up_reg[i] > floor_in);
            dn_yield[i] = (CW'(i) >= dn_used_reg) || (dn_reg[i] < floor_in);
        end
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            up_next[i] = up_reg[i];
            dn_next[i] = dn_reg[i];
            if (do_up_ins && up_yield[i]) begin
                if (i == 0) up_next[i] = floor_in;
                else if (!up_yield[i-1]) up_next[i] = floor_in;
                else up_next[i] = up_reg[i-1];
            end else if (do_up_rem && i < QUEUE_DEPTH - 1) begin
                up_next[i] = up_reg[i+1];
            end
            if (do_dn_ins && dn_yield[i]) begin
                if (i == 0) dn_next[i] = floor_in;
                else if (!dn_yield[i-1]) dn_next[i] = floor_in;
                else dn_next[i] = dn_reg[i-1];
            end else if (do_dn_rem && i < QUEUE_DEPTH - 1) begin
                dn_next[i] = dn_reg[i+1];
            end
        end
    end

    always_comb begin
        up_used_next = up_used_reg;
        dn_used_next = dn_used_reg;
        if (do_up_ins) up_used_next = up_used_reg + CW'(1);
        if (do_up_rem) up_used_next = up_used_reg - CW'(1);
        if (do_dn_ins) dn_used_next = dn_used_reg + CW'(1);
        if (do_dn_rem) dn_used_next = dn_used_reg - CW'(1);
    end

    // ---------------- result formatting ----------------
    logic [FB-1:0]   upf, dnf;
    logic [FB+7:0]   upf_ext, dnf_ext;
    logic [CW+4:0]   upc_ext, dnc_ext;
    logic [FLOOR_W-1:0] upf8, dnf8, nxt8;

    always_comb begin
        upf     = (up_used_next != '0) ? up_next[0] : '0;
        dnf     = (dn_used_next != '0) ? dn_next[0] : '0;
        upf_ext = {8'd0, upf};
        dnf_ext = {8'd0, dnf};
        upf8    = upf_ext[7:0];
        dnf8    = dnf_ext[7:0];
        nxt8    = (dir == DIR_UP) ? upf8 : dnf8;
        upc_ext = {5'd0, up_used_next};
        dnc_ext = {5'd0, dn_used_next};
        m_tdata_next = {4'd0,
                        (up_used_next != '0) || (dn_used_next != '0),
                        (up_used_next == '0),
                        dnc_ext[COUNT_W-1:0],
                        upc_ext[COUNT_W-1:0],
                        nxt8, dnf8, upf8};
        m_tuser_next = status;
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_used_reg  <= '0;
            dn_used_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                up_used_reg  <= up_used_next;
                dn_used_reg  <= dn_used_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            up_reg      <= up_next;
            dn_reg      <= dn_next;
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (up_used_reg <= CW'(QUEUE_DEPTH)) && (dn_used_reg <= CW'(QUEUE_DEPTH)))
        else $error("queue count above depth");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg == ST_FULL) |->
            (up_used_reg == CW'(QUEUE_DEPTH) || dn_used_reg == CW'(QUEUE_DEPTH)))
        else $error("full status reported with no full queue");

    a_up_remove: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && cmd == CMD_REM_UP && up_used_reg != '0) |=>
            (up_used_reg == $past(up_used_reg) - CW'(1)))
        else $error("up removal did not decrement count");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg == ST_EMPTY) |->
            (up_used_reg == '0 || dn_used_reg == '0))
        else $error("empty status reported with no empty queue");

endmodule

`default_nettype wire

### tb/sv/floor_request_dual_priority_queue_tb.sv
// Self-checking testbench for floor_request_dual_priority_queue: an in-file
// scoreboard predicts every report and checks it. Depends on frdpq_pkg and the DUT.
`timescale 1ns / 1ps

module floor_request_dual_priority_queue_tb;
    import frdpq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RPT_W       = M_TDATA_W + M_TUSER_W;   // tuser sits above tdata
    localparam int N_FIELDS    = 9;
    localparam int ITEM_TARGET = 950;
    localparam int HOLD_CYCLES = 60;

    // Scoreboard: keeps its own copy of both sorted queues, predicts one
    // report per accepted transaction and checks reports in order.
    class floor_queue_scoreboard;
        logic [FLOOR_W-1:0] held[2][DEPTH];   // [DIR_DOWN] descending, [DIR_UP] ascending
        int                 held_n[2];
        logic [RPT_W-1:0]   expected_reports[$];
        int mismatches;
        int checked;
        int full_drops;
        int empty_ignores;
        int nops;
        int peak[2];
        // report fields, lowest bit up; bits 39:36 are padding and must stay zero
        string fld_name[N_FIELDS] = '{"up_front", "down_front", "next_floor", "up_count",
                                      "down_count", "up_empty", "any_pending", "pad",
                                      "status"};
        int    fld_lo[N_FIELDS]   = '{0, 8, 16, 24, 29, 34, 35, 36, 40};
        int    fld_w[N_FIELDS]    = '{8, 8, 8, 5, 5, 1, 1, 4, 2};

        function new();
            held_n = '{0, 0};
            peak   = '{0, 0};
            mismatches = 0;
            checked = 0;
            full_drops = 0;
            empty_ignores = 0;
            nops = 0;
        endfunction

        // New floor goes behind any equal floors.
        function void insert_floor(logic side, logic [FLOOR_W-1:0] v);
            int pos;
            pos = 0;
            while (pos < held_n[side] &&
                   !((side == DIR_UP) ? (held[side][pos] > v) : (held[side][pos] < v)))
                pos++;
            for (int i = held_n[side]; i > pos; i--)
                held[side][i] = held[side][i-1];
            held[side][pos] = v;
            held_n[side]++;
            if (held_n[side] > peak[side])
                peak[side] = held_n[side];
        endfunction

        function void remove_front(logic side);
            for (int i = 1; i < held_n[side]; i++)
                held[side][i-1] = held[side][i];
            held_n[side]--;
        endfunction

        function void note_request(cmd_t cmd, logic dir, logic [FLOOR_W-1:0] fl);
            status_t            st;
            logic [FLOOR_W-1:0] upf;
            logic [FLOOR_W-1:0] dnf;
            logic [RPT_W-1:0]   rpt;
            st = ST_DONE;
            case (cmd)
                CMD_ADD: begin
                    if (held_n[dir] >= DEPTH)
                        st = ST_FULL;
                    else
                        insert_floor(dir, fl);
                end
                CMD_REM_UP: begin
                    if (held_n[DIR_UP] == 0)
                        st = ST_EMPTY;
                    else
                        remove_front(DIR_UP);
                end
                CMD_REM_DOWN: begin
                    if (held_n[DIR_DOWN] == 0)
                        st = ST_EMPTY;
                    else
                        remove_front(DIR_DOWN);
                end
                default: nops++;
            endcase
            if (st == ST_FULL)  full_drops++;
            if (st == ST_EMPTY) empty_ignores++;
            upf = (held_n[DIR_UP] != 0) ? held[DIR_UP][0] : '0;
            dnf = (held_n[DIR_DOWN] != 0) ? held[DIR_DOWN][0] : '0;
            rpt = '0;
            rpt[7:0]   = upf;
            rpt[15:8]  = dnf;
            rpt[23:16] = (dir == DIR_UP) ? upf : dnf;
            rpt[28:24] = COUNT_W'(held_n[DIR_UP]);
            rpt[33:29] = COUNT_W'(held_n[DIR_DOWN]);
            rpt[34]    = (held_n[DIR_UP] == 0);
            rpt[35]    = (held_n[DIR_UP] != 0) || (held_n[DIR_DOWN] != 0);
            rpt[41:40] = st;
            expected_reports = {expected_reports, rpt};
        endfunction

        function void check_report(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            logic [RPT_W-1:0] act;
            logic [RPT_W-1:0] exp_rpt;
            logic [RPT_W-1:0] mask;
            act = {tuser, tdata};
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected report tdata=%h tuser=%h", $realtime, tdata, tuser);
                return;
            end
            exp_rpt = expected_reports.pop_front();
            checked++;
            for (int f = 0; f < N_FIELDS; f++) begin
                mask = (RPT_W'(1) << fld_w[f]) - 1;
                if (((act >> fld_lo[f]) & mask) !== ((exp_rpt >> fld_lo[f]) & mask)) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: report %0d field %s expected %0d got %0d", $realtime,
                                 checked, fld_name[f], (exp_rpt >> fld_lo[f]) & mask,
                                 (act >> fld_lo[f]) & mask);
                end
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;   // [1:0] command, [2] direction
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // [7:0] up_front, [15:8] down_front, [23:16] next_floor,
                                     // [28:24] up_count, [33:29] down_count, [34] up_empty,
                                     // [35] any_pending, [39:36] zero
    logic [M_TUSER_W-1:0] m_tuser;   // [1:0] status

    floor_queue_scoreboard sb;
    int requests_sent = 0;
    bit tx_idle_en  = 1'b1;   // sender inserts random gaps
    bit rx_idle_en  = 1'b1;   // receiver drops tready at random
    bit rx_hold_req = 1'b0;   // one-shot long back-pressure

    floor_request_dual_priority_queue uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop: reports TB_ERROR and ends the run.
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Transaction monitor: both channels are sampled on the rising edge, inputs
    // having settled since the falling edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_report(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                sb.note_request(cmd_t'(s_tuser[1:0]), s_tuser[2], s_tdata);
        end
    end

    // Receiver: ~20% random stalls while enabled; on request it holds tready
    // low so the output register stays full and the input side backs up.
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                rx_hold_req = 1'b0;
            end else begin
                m_tready <= !(rx_idle_en && ($urandom_range(99) < 20));
            end
        end
    end

    // Offer one command and return once the block has accepted it. Each
    // falling edge gets a single assignment to tvalid.
    task automatic send_txn(input cmd_t cmd, input logic dir, input logic [FLOOR_W-1:0] fl);
        int gap;
        gap = 0;
        if (tx_idle_en && ($urandom_range(99) < 20))
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= fl;
        s_tuser  <= {dir, cmd};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    // Floors lean toward the extremes and a tiny range so duplicates are common.
    function automatic logic [FLOOR_W-1:0] pick_floor();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r <= 3) return FLOOR_W'($urandom_range(3));
        return FLOOR_W'($urandom_range(255));
    endfunction

    // Random traffic in bursts: fill runs push a queue past full, drain runs
    // empty it and keep removing, mixed runs interleave everything.
    task automatic run_random(input int target);
        int   kind;
        int   n;
        int   r;
        logic side;
        while (requests_sent < target) begin
            kind = $urandom_range(9);
            side = 1'($urandom_range(1));
            n    = $urandom_range(12, 20);
            if (kind <= 2) begin
                repeat (n) send_txn(CMD_ADD, side, pick_floor());
            end else if (kind <= 4) begin
                repeat (n)
                    send_txn((side == DIR_UP) ? CMD_REM_UP : CMD_REM_DOWN,
                             1'($urandom_range(1)), pick_floor());
            end else begin
                n = $urandom_range(5, 30);
                repeat (n) begin
                    r = $urandom_range(99);
                    if (r < 45)
                        send_txn(CMD_ADD, 1'($urandom_range(1)), pick_floor());
                    else if (r < 70)
                        send_txn(CMD_REM_UP, 1'($urandom_range(1)), pick_floor());
                    else if (r < 95)
                        send_txn(CMD_REM_DOWN, 1'($urandom_range(1)), pick_floor());
                    else
                        send_txn(CMD_NOP, 1'($urandom_range(1)), pick_floor());
                end
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: removals from empty queues, no-op in both directions,
        // extreme and equal floors in each queue, then drain past empty.
        send_txn(CMD_REM_UP,   DIR_UP,   8'h00);
        send_txn(CMD_REM_DOWN, DIR_DOWN, 8'hFF);
        send_txn(CMD_NOP,      DIR_DOWN, 8'hA5);
        send_txn(CMD_ADD,      DIR_UP,   8'hFF);
        send_txn(CMD_ADD,      DIR_UP,   8'h00);
        send_txn(CMD_ADD,      DIR_UP,   8'hFF);
        send_txn(CMD_ADD,      DIR_UP,   8'h80);
        send_txn(CMD_ADD,      DIR_DOWN, 8'h00);
        send_txn(CMD_ADD,      DIR_DOWN, 8'hFF);
        send_txn(CMD_ADD,      DIR_DOWN, 8'h00);
        send_txn(CMD_ADD,      DIR_DOWN, 8'h55);
        send_txn(CMD_NOP,      DIR_UP,   8'h5A);
        send_txn(CMD_REM_UP,   DIR_DOWN, 8'h33);
        send_txn(CMD_REM_DOWN, DIR_UP,   8'hCC);
        repeat (3) send_txn(CMD_REM_UP, DIR_UP, 8'h00);
        send_txn(CMD_REM_UP,   DIR_DOWN, 8'h00);   // up empty, down still holds entries
        repeat (4) send_txn(CMD_REM_DOWN, DIR_DOWN, 8'h00);

        // Random traffic with idling on both sides.
        run_random(400);

        // No idling at all; the long receiver hold-off happens at the start
        // while the sender keeps offering.
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b0;
        rx_hold_req = 1'b1;
        run_random(650);

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        run_random(ITEM_TARGET);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);   // a stray late report would show here

        $display("Sent %0d commands, checked %0d reports (%0d mismatches).",
                 requests_sent, sb.checked, sb.mismatches);
        $display("Full drops %0d, empty removals %0d, no-ops %0d, peak depth up %0d down %0d.",
                 sb.full_drops, sb.empty_ignores, sb.nops, sb.peak[DIR_UP], sb.peak[DIR_DOWN]);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
